// ===== sv/model_matrix_builder_defines.svh =====
// Assertion macros for the model matrix builder.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef MODEL_MATRIX_BUILDER_DEFINES_SVH
`define MODEL_MATRIX_BUILDER_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define MMB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define MMB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/mmb_pkg.sv =====
// Shared constants, types and arithmetic helpers of the model matrix builder.
// No dependencies; the design modules and the testbench use it by scoped names.
package mmb_pkg;

  localparam int FRAC_BITS       = 16;
  localparam int TRIG_TABLE_BITS = 10;

  localparam int DEG_W   = 26;
  localparam int ELEM_W  = 32;
  localparam int PH_W    = TRIG_TABLE_BITS + 2;
  localparam int ARG_W   = TRIG_TABLE_BITS + 1;
  localparam int NUM_W   = DEG_W + TRIG_TABLE_BITS + 1;
  localparam int XA_W    = NUM_W - FRAC_BITS - 1;
  localparam int DIV_SH  = XA_W + 6;
  localparam int RECIP_W = DIV_SH - 4;
  localparam int QP_W    = XA_W + RECIP_W;
  localparam longint unsigned RECIP = ((64'd1 << DIV_SH) + 64'd44) / 64'd45;
  localparam int R_W     = 33;
  localparam int A_W     = 34;
  localparam int TERM_W  = 66 - FRAC_BITS;
  localparam int SUM_W   = TERM_W + 3;
  localparam int NSTG    = 16;

  localparam logic [31:0] SC1 = 32'd1686629713;
  localparam logic [31:0] SC3 = 32'd693598668;
  localparam logic [31:0] SC5 = 32'd85569305;
  localparam logic [31:0] SC7 = 32'd5026998;
  localparam logic [31:0] SC9 = 32'd172272;
  localparam logic [31:0] ONE_Q30 = 32'd1 << 30;
  localparam logic [31:0] ONE_FIX = 32'd1 << FRAC_BITS;

  localparam logic [1:0] COL_FIRST = 2'd0;
  localparam logic [1:0] COL_LAST  = 2'd3;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [DEG_W-1:0]  deg_t;
  typedef logic [XA_W-1:0]          xa_t;
  typedef logic [QP_W-1:0]          qp_t;
  typedef logic [NUM_W-1:0]         num_t;
  typedef logic [PH_W-1:0]          ph_t;
  typedef logic [ARG_W-1:0]         arg_t;
  typedef logic signed [R_W-1:0]    r_t;
  typedef logic signed [A_W-1:0]    a_t;
  typedef logic signed [TERM_W-1:0] term_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [65:0]       full_t;

  typedef struct packed {
    logic neg;
    arg_t k;
  } qarg_t;

  typedef struct packed {
    elem_t pos_x;
    elem_t pos_y;
    elem_t pos_z;
    elem_t scale_x;
    elem_t scale_y;
    elem_t scale_z;
    elem_t pivot_x;
    elem_t pivot_y;
    elem_t pivot_z;
  } xform_t;

  // Arithmetic right shift rounding half away from zero.
  function automatic logic signed [79:0] rnd_shr(input logic signed [79:0] v, input int n);
    logic [79:0] m;
    logic [79:0] r;
    m = v[79] ? 80'(-v) : 80'(v);
    r = (m + (80'd1 << (n - 1))) >> n;
    return v[79] ? -$signed(r) : $signed(r);
  endfunction

  function automatic elem_t mulq30(input elem_t a, input elem_t b);
    logic signed [63:0] p;
    p = a * b;
    return elem_t'(rnd_shr(80'(p), 30));
  endfunction

  function automatic logic [31:0] mulu30(input logic [30:0] a, input logic [31:0] b);
    logic [62:0] p;
    p = 63'(a) * 63'(b);
    return 32'(p >> 30);
  endfunction

  function automatic elem_t sat32(input logic signed [79:0] v);
    if (v > 80'sh7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -80'sh8000_0000) begin
      return 32'sh8000_0000;
    end
    return elem_t'(v);
  endfunction

  // Phase to quarter-turn argument and sign of the sine.
  function automatic qarg_t ph_to_arg(input ph_t ph);
    qarg_t a;
    arg_t  k;
    k = arg_t'(ph[TRIG_TABLE_BITS-1:0]);
    a.k = ph[TRIG_TABLE_BITS] ? (arg_t'(1) << TRIG_TABLE_BITS) - k : k;
    a.neg = ph[TRIG_TABLE_BITS+1];
    return a;
  endfunction

endpackage

// ===== sv/mmb_angle.sv =====
// Degrees to phase conversion for one angle, two register stages.
// Depends on mmb_pkg.
module mmb_angle (
  input  logic                clk,
  input  logic                en,
  input  mmb_pkg::deg_t       deg,
  output mmb_pkg::qarg_t      sin_arg,
  output mmb_pkg::qarg_t      cos_arg
);

  mmb_pkg::deg_t mag;
  mmb_pkg::num_t num;
  mmb_pkg::xa_t  xa_nxt;
  mmb_pkg::xa_t  xa_r;
  logic          neg_r;
  mmb_pkg::qp_t  qp;
  mmb_pkg::ph_t  m;
  mmb_pkg::ph_t  ph_nxt;
  mmb_pkg::ph_t  ph_r;

  always_comb begin
    mag = deg[mmb_pkg::DEG_W-1] ? mmb_pkg::deg_t'(-deg) : deg;
    num = (mmb_pkg::num_t'(unsigned'(mag)) << mmb_pkg::TRIG_TABLE_BITS)
          + (mmb_pkg::num_t'(45) << mmb_pkg::FRAC_BITS);
    // 90 << FRAC_BITS is 45 << (FRAC_BITS + 1): shift off the power of two here.
    xa_nxt = mmb_pkg::xa_t'(num >> (mmb_pkg::FRAC_BITS + 1));
    // Division by 45 through an exact reciprocal multiply.
    qp = mmb_pkg::qp_t'(xa_r) * mmb_pkg::qp_t'(mmb_pkg::RECIP);
    m = mmb_pkg::ph_t'(qp >> mmb_pkg::DIV_SH);
    ph_nxt = neg_r ? -m : m;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xa_r  <= xa_nxt;
      neg_r <= deg[mmb_pkg::DEG_W-1];
      ph_r  <= ph_nxt;
    end
  end

  assign sin_arg = mmb_pkg::ph_to_arg(ph_r);
  assign cos_arg = mmb_pkg::ph_to_arg(ph_r + (mmb_pkg::ph_t'(1) << mmb_pkg::TRIG_TABLE_BITS));

endmodule

// ===== sv/mmb_qsin.sv =====
// Quarter-turn sine polynomial, six register stages, one multiply each.
// Depends on mmb_pkg.
module mmb_qsin (
  input  logic           clk,
  input  logic           en,
  input  mmb_pkg::qarg_t arg,
  output mmb_pkg::elem_t val
);

  logic [30:0] x_in;
  logic [30:0] x2_nxt;
  logic [30:0] x_r  [5];
  logic [30:0] x2_r [4];
  logic        neg_r [5];
  logic [31:0] p_r  [4];
  logic [31:0] pf;
  logic [31:0] pc;
  mmb_pkg::elem_t s_nxt;
  mmb_pkg::elem_t s_r;

  always_comb begin
    x_in   = 31'(arg.k) << (30 - mmb_pkg::TRIG_TABLE_BITS);
    x2_nxt = 31'(mmb_pkg::mulu30(x_in, 32'(x_in)));
    pf     = mmb_pkg::mulu30(x_r[4], p_r[3]);
    pc     = (pf > mmb_pkg::ONE_Q30) ? mmb_pkg::ONE_Q30 : pf;
    s_nxt  = neg_r[4] ? -$signed(pc) : $signed(pc);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]   <= x_in;
      x2_r[0]  <= x2_nxt;
      neg_r[0] <= arg.neg;
      for (int i = 1; i < 5; i++) begin
        x_r[i]   <= x_r[i-1];
        neg_r[i] <= neg_r[i-1];
      end
      for (int i = 1; i < 4; i++) begin
        x2_r[i] <= x2_r[i-1];
      end
      p_r[0] <= mmb_pkg::SC7 - mmb_pkg::mulu30(x2_r[0], mmb_pkg::SC9);
      p_r[1] <= mmb_pkg::SC5 - mmb_pkg::mulu30(x2_r[1], p_r[0]);
      p_r[2] <= mmb_pkg::SC3 - mmb_pkg::mulu30(x2_r[2], p_r[1]);
      p_r[3] <= mmb_pkg::SC1 - mmb_pkg::mulu30(x2_r[3], p_r[2]);
      s_r    <= s_nxt;
    end
  end

  assign val = s_r;

endmodule

// ===== sv/mmb_rot.sv =====
// Rotation matrix Rx*Ry*Rz and its product with the scale, four register stages.
// Depends on mmb_pkg.
module mmb_rot (
  input  logic           clk,
  input  logic           en,
  input  mmb_pkg::elem_t sn  [3],
  input  mmb_pkg::elem_t cs  [3],
  input  mmb_pkg::elem_t scl [3],
  output mmb_pkg::a_t    amat [3][3]
);

  mmb_pkg::elem_t sxsy_r, cxsy_r, cycz_r, cysz_r, cxsz_r, cxcz_r;
  mmb_pkg::elem_t sxsz_r, sxcz_r, sxcy_r, cxcy_r, sy_r, cz_r, sz_r;
  mmb_pkg::elem_t t1_r, t2_r, t3_r, t4_r;
  mmb_pkg::elem_t cycz2_r, cysz2_r, sy2_r, cxsz2_r, cxcz2_r;
  mmb_pkg::elem_t sxsz2_r, sxcz2_r, sxcy2_r, cxcy2_r;
  mmb_pkg::r_t    r_r [3][3];
  mmb_pkg::a_t    a_r [3][3];
  // Full-width rotation times scale products.
  logic signed [64:0] rs [3][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        rs[i][j] = r_r[i][j] * scl[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sxsy_r <= mmb_pkg::mulq30(sn[0], sn[1]);
      cxsy_r <= mmb_pkg::mulq30(cs[0], sn[1]);
      cycz_r <= mmb_pkg::mulq30(cs[1], cs[2]);
      cysz_r <= mmb_pkg::mulq30(cs[1], sn[2]);
      cxsz_r <= mmb_pkg::mulq30(cs[0], sn[2]);
      cxcz_r <= mmb_pkg::mulq30(cs[0], cs[2]);
      sxsz_r <= mmb_pkg::mulq30(sn[0], sn[2]);
      sxcz_r <= mmb_pkg::mulq30(sn[0], cs[2]);
      sxcy_r <= mmb_pkg::mulq30(sn[0], cs[1]);
      cxcy_r <= mmb_pkg::mulq30(cs[0], cs[1]);
      sy_r   <= sn[1];
      cz_r   <= cs[2];
      sz_r   <= sn[2];

      t1_r    <= mmb_pkg::mulq30(sxsy_r, cz_r);
      t2_r    <= mmb_pkg::mulq30(sxsy_r, sz_r);
      t3_r    <= mmb_pkg::mulq30(cxsy_r, cz_r);
      t4_r    <= mmb_pkg::mulq30(cxsy_r, sz_r);
      cycz2_r <= cycz_r;
      cysz2_r <= cysz_r;
      sy2_r   <= sy_r;
      cxsz2_r <= cxsz_r;
      cxcz2_r <= cxcz_r;
      sxsz2_r <= sxsz_r;
      sxcz2_r <= sxcz_r;
      sxcy2_r <= sxcy_r;
      cxcy2_r <= cxcy_r;

      r_r[0][0] <= mmb_pkg::r_t'(cycz2_r);
      r_r[0][1] <= -mmb_pkg::r_t'(cysz2_r);
      r_r[0][2] <= mmb_pkg::r_t'(sy2_r);
      r_r[1][0] <= mmb_pkg::r_t'(t1_r) + mmb_pkg::r_t'(cxsz2_r);
      r_r[1][1] <= mmb_pkg::r_t'(cxcz2_r) - mmb_pkg::r_t'(t2_r);
      r_r[1][2] <= -mmb_pkg::r_t'(sxcy2_r);
      r_r[2][0] <= mmb_pkg::r_t'(sxsz2_r) - mmb_pkg::r_t'(t3_r);
      r_r[2][1] <= mmb_pkg::r_t'(t4_r) + mmb_pkg::r_t'(sxcz2_r);
      r_r[2][2] <= mmb_pkg::r_t'(cxcy2_r);

      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          a_r[i][j] <= mmb_pkg::a_t'(mmb_pkg::rnd_shr(80'(rs[i][j]), 30));
        end
      end
    end
  end

  assign amat = a_r;

endmodule

// ===== sv/mmb_col.sv =====
// Translation column and saturation of the final matrix, three register stages.
// Depends on mmb_pkg.
module mmb_col (
  input  logic           clk,
  input  logic           en,
  input  mmb_pkg::a_t    amat [3][3],
  input  mmb_pkg::elem_t piv  [3],
  input  mmb_pkg::elem_t pos  [3],
  output mmb_pkg::elem_t mat  [4][3]
);

  logic signed [49:0] ph_r [3][3];
  logic signed [50:0] pl_r [3][3];
  mmb_pkg::a_t        a1_r [3][3];
  mmb_pkg::a_t        a2_r [3][3];
  mmb_pkg::term_t     t_r  [3][3];
  mmb_pkg::full_t     full [3][3];
  mmb_pkg::sum_t      sum  [3];
  mmb_pkg::elem_t     m_r  [4][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        full[i][j] = (mmb_pkg::full_t'(ph_r[i][j]) <<< 16) + mmb_pkg::full_t'(pl_r[i][j]);
      end
      sum[i] = mmb_pkg::sum_t'(pos[i]) - mmb_pkg::sum_t'(t_r[i][0])
               - mmb_pkg::sum_t'(t_r[i][1]) - mmb_pkg::sum_t'(t_r[i][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          // Pivot split in halves keeps each multiply at 34 by 17 bits or less.
          ph_r[i][j] <= amat[i][j] * $signed(piv[j][31:16]);
          pl_r[i][j] <= amat[i][j] * $signed({1'b0, piv[j][15:0]});
          a1_r[i][j] <= amat[i][j];
          a2_r[i][j] <= a1_r[i][j];
          t_r[i][j]  <= mmb_pkg::term_t'(mmb_pkg::rnd_shr(80'(full[i][j]),
                                                          mmb_pkg::FRAC_BITS));
          m_r[j][i]  <= mmb_pkg::sat32(80'(a2_r[i][j]));
        end
        m_r[3][i] <= mmb_pkg::sat32(80'(sum[i]));
      end
    end
  end

  assign mat = m_r;

endmodule

// ===== sv/model_matrix_builder.sv =====
// Model matrix builder: M = T(pos) * Rx * Ry * Rz * S(scale) * T(-pivot), Q16.16.
// Each matrix leaves as four column transactions, column 0 first, once it reaches stage 15;
// the column serializer on the output holds the pipeline until the fourth column is loaded.
// Reset (synchronous, active low) empties the pipeline and the output register.
// Payload registers are not reset.
`include "model_matrix_builder_defines.svh"

module model_matrix_builder (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pos_x, pos_y, pos_z, rot_x_deg, rot_y_deg, rot_z_deg, scale_x, scale_y, scale_z,
  // pivot_x, pivot_y, pivot_z, then two zero bits.
  input  logic [367:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // elem_row0, elem_row1, elem_row2, elem_row3.
  output logic [127:0] out_tdata,
  // column_index.
  output logic [1:0]   out_tuser,
  output logic         out_tlast
);

  // The pipeline advances as a whole. Stage 0 holds the accepted transaction; stages 1-2
  // convert the angles to phases, 3-8 evaluate the sine polynomial, 9-12 build the rotation
  // and scale it, 13-15 form the translation column and saturate. Stage 15 is held until
  // the serializer has loaded its fourth column into the output register.
  logic                adv;
  logic                out_ok;
  logic                out_load;
  logic                v_r [mmb_pkg::NSTG];
  mmb_pkg::xform_t     pl_r [mmb_pkg::NSTG-1];
  mmb_pkg::xform_t     in_xf;
  mmb_pkg::deg_t       rot_r [3];
  logic [1:0]          col_cnt_r;
  logic                out_tvalid_r;
  logic [1:0]          out_col_r;
  logic                out_last_r;
  mmb_pkg::elem_t      out_row_r [4];

  mmb_pkg::qarg_t      sarg [3];
  mmb_pkg::qarg_t      carg [3];
  mmb_pkg::elem_t      sn   [3];
  mmb_pkg::elem_t      cs   [3];
  mmb_pkg::elem_t      scl  [3];
  mmb_pkg::elem_t      piv  [3];
  mmb_pkg::elem_t      pos  [3];
  mmb_pkg::a_t         amat [3][3];
  mmb_pkg::elem_t      mat  [4][3];

  assign in_xf.pos_x   = in_tdata[31:0];
  assign in_xf.pos_y   = in_tdata[63:32];
  assign in_xf.pos_z   = in_tdata[95:64];
  assign in_xf.scale_x = in_tdata[205:174];
  assign in_xf.scale_y = in_tdata[237:206];
  assign in_xf.scale_z = in_tdata[269:238];
  assign in_xf.pivot_x = in_tdata[301:270];
  assign in_xf.pivot_y = in_tdata[333:302];
  assign in_xf.pivot_z = in_tdata[365:334];

  // Output register is free when empty or being drained this cycle.
  assign out_ok    = !out_tvalid_r || out_tready;
  assign out_load  = v_r[mmb_pkg::NSTG-1] && out_ok;
  assign adv       = !v_r[mmb_pkg::NSTG-1] || (out_load && (col_cnt_r == mmb_pkg::COL_LAST));
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mmb_pkg::NSTG; i++) begin
        v_r[i] <= 1'b0;
      end
    end else if (adv) begin
      v_r[0] <= in_tvalid;
      for (int i = 1; i < mmb_pkg::NSTG; i++) begin
        v_r[i] <= v_r[i-1];
      end
    end
  end

  // Side data travels alongside the valid bits until its stage needs it.
  always_ff @(posedge clk) begin
    if (adv) begin
      pl_r[0]  <= in_xf;
      rot_r[0] <= in_tdata[121:96];
      rot_r[1] <= in_tdata[147:122];
      rot_r[2] <= in_tdata[173:148];
      for (int i = 1; i < mmb_pkg::NSTG - 1; i++) begin
        pl_r[i] <= pl_r[i-1];
      end
    end
  end

  assign scl[0] = pl_r[11].scale_x;
  assign scl[1] = pl_r[11].scale_y;
  assign scl[2] = pl_r[11].scale_z;
  assign piv[0] = pl_r[12].pivot_x;
  assign piv[1] = pl_r[12].pivot_y;
  assign piv[2] = pl_r[12].pivot_z;
  assign pos[0] = pl_r[14].pos_x;
  assign pos[1] = pl_r[14].pos_y;
  assign pos[2] = pl_r[14].pos_z;

  for (genvar g = 0; g < 3; g++) begin : g_axis
    mmb_angle u_angle (
      .clk     (clk),
      .en      (adv),
      .deg     (rot_r[g]),
      .sin_arg (sarg[g]),
      .cos_arg (carg[g])
    );
    mmb_qsin u_sin (
      .clk (clk),
      .en  (adv),
      .arg (sarg[g]),
      .val (sn[g])
    );
    mmb_qsin u_cos (
      .clk (clk),
      .en  (adv),
      .arg (carg[g]),
      .val (cs[g])
    );
  end

  mmb_rot u_rot (
    .clk  (clk),
    .en   (adv),
    .sn   (sn),
    .cs   (cs),
    .scl  (scl),
    .amat (amat)
  );

  mmb_col u_col (
    .clk  (clk),
    .en   (adv),
    .amat (amat),
    .piv  (piv),
    .pos  (pos),
    .mat  (mat)
  );

  // Column serializer: walks the held matrix one column per output transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r    <= mmb_pkg::COL_FIRST;
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      col_cnt_r    <= col_cnt_r + 2'd1;
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_col_r  <= col_cnt_r;
      out_last_r <= (col_cnt_r == mmb_pkg::COL_LAST);
      for (int i = 0; i < 3; i++) begin
        out_row_r[i] <= mat[col_cnt_r][i];
      end
      out_row_r[3] <= (col_cnt_r == mmb_pkg::COL_LAST) ? mmb_pkg::ONE_FIX : '0;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_row_r[3], out_row_r[2], out_row_r[1], out_row_r[0]};
  assign out_tuser  = out_col_r;
  assign out_tlast  = out_last_r;

  // A column that is not the last is followed at once by the next column of the matrix.
  `MMB_ASSERT_NEXT(a_col_next, out_tvalid && out_tready && !out_tlast, out_tvalid && (out_tuser == 2'($past(out_tuser) + 2'd1)), "column sequence broken")
  // After the last column, the next transaction starts a new matrix.
  `MMB_ASSERT_NEXT(a_col_wrap, out_tvalid && out_tready && out_tlast, !out_tvalid || (out_tuser == mmb_pkg::COL_FIRST), "matrix did not restart at column 0")
  // A partly sent matrix is still held in the final stage.
  `MMB_ASSERT_NOW(a_col_hold, col_cnt_r != mmb_pkg::COL_FIRST, v_r[mmb_pkg::NSTG-1], "serializer lost its matrix")

endmodule

// ===== tb/model_matrix_builder_tb.sv =====
// Self-checking testbench for the model matrix builder (TRS matrix with pivot).
// Depends on mmb_pkg and model_matrix_builder; predicts each column internally.
module model_matrix_builder_tb;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [367:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tlast;

  // One expected column of the model matrix.
  typedef struct {
    logic [1:0]  col;
    logic [31:0] row0;
    logic [31:0] row1;
    logic [31:0] row2;
    logic [31:0] row3;
    logic        last;
  } column_t;

  logic [367:0] pending_xforms[$];
  column_t      expected_columns[$];
  int           failures;
  int           cycle_count;
  bit           in_quiet;
  bit           out_quiet;
  bit           stimulus_done;
  int           sent_count;
  bit           drained_once;
  bit           in_tready_seen;

  model_matrix_builder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Rounding shift: the magnitude is rounded half up, then the sign restored.
  function automatic longint round_shift(input longint v, input int n);
    longint unsigned m;
    m = (v < 0) ? longint'(-v) : v;
    m = (m + (64'd1 << (n - 1))) >> n;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // Sine over one quarter turn, Q30, from a ninth-order odd polynomial.
  function automatic longint quarter_sine(input longint unsigned k);
    longint unsigned x, x2, p;
    x  = k << (30 - mmb_pkg::TRIG_TABLE_BITS);
    x2 = (x * x) >> 30;
    p  = 64'd172272;
    p  = 64'd5026998 - ((x2 * p) >> 30);
    p  = 64'd85569305 - ((x2 * p) >> 30);
    p  = 64'd693598668 - ((x2 * p) >> 30);
    p  = 64'd1686629713 - ((x2 * p) >> 30);
    p  = (x * p) >> 30;
    if (p > (64'd1 << 30)) p = 64'd1 << 30;
    return p;
  endfunction

  function automatic longint phase_sine(input longint unsigned ph);
    longint unsigned quad, k;
    longint s;
    quad = (ph >> mmb_pkg::TRIG_TABLE_BITS) & 3;
    k    = ph & ((64'd1 << mmb_pkg::TRIG_TABLE_BITS) - 1);
    s    = quad[0] ? quarter_sine((64'd1 << mmb_pkg::TRIG_TABLE_BITS) - k) : quarter_sine(k);
    return quad[1] ? -s : s;
  endfunction

  // Degrees (Q10.16) to a phase index, rounded on the magnitude, wrapped to a turn.
  function automatic longint unsigned angle_phase(input logic signed [25:0] deg);
    longint r;
    longint unsigned a, den, m;
    r   = deg;
    a   = (r < 0) ? -r : r;
    den = 64'd90 << mmb_pkg::FRAC_BITS;
    m   = ((a << mmb_pkg::TRIG_TABLE_BITS) + (den >> 1)) / den;
    if (r < 0) m = -m;
    return m & ((64'd1 << (mmb_pkg::TRIG_TABLE_BITS + 2)) - 1);
  endfunction

  function automatic longint q30_mul(input longint a, input longint b);
    return round_shift(a * b, 30);
  endfunction

  // Works out the four columns of one transform and queues them.
  task automatic predict_matrix(input logic [367:0] d);
    longint pos[3], scl[3], piv[3], sn[3], cs[3];
    longint rot[3][3], prod[3][3];
    longint sxsy, cxsy, v;
    longint unsigned ph;
    column_t c;
    for (int i = 0; i < 3; i++) begin
      pos[i] = $signed(d[32*i +: 32]);
      ph     = angle_phase(d[96 + 26*i +: 26]);
      scl[i] = $signed(d[174 + 32*i +: 32]);
      piv[i] = $signed(d[270 + 32*i +: 32]);
      sn[i]  = phase_sine(ph);
      cs[i]  = phase_sine((ph + (64'd1 << mmb_pkg::TRIG_TABLE_BITS)) &
                          ((64'd1 << (mmb_pkg::TRIG_TABLE_BITS + 2)) - 1));
    end
    sxsy = q30_mul(sn[0], sn[1]);
    cxsy = q30_mul(cs[0], sn[1]);
    rot[0][0] = q30_mul(cs[1], cs[2]);
    rot[0][1] = -q30_mul(cs[1], sn[2]);
    rot[0][2] = sn[1];
    rot[1][0] = q30_mul(sxsy, cs[2]) + q30_mul(cs[0], sn[2]);
    rot[1][1] = -q30_mul(sxsy, sn[2]) + q30_mul(cs[0], cs[2]);
    rot[1][2] = -q30_mul(sn[0], cs[1]);
    rot[2][0] = -q30_mul(cxsy, cs[2]) + q30_mul(sn[0], sn[2]);
    rot[2][1] = q30_mul(cxsy, sn[2]) + q30_mul(sn[0], cs[2]);
    rot[2][2] = q30_mul(cs[0], cs[1]);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod[i][j] = round_shift(rot[i][j] * scl[j], 30);
      end
    end
    for (int col = 0; col < 4; col++) begin
      logic [31:0] e[3];
      for (int i = 0; i < 3; i++) begin
        if (col < 3) begin
          v = prod[i][col];
        end else begin
          // Translation column: rotation entries stay near one, so each scaled
          // entry times a pivot stays well inside 64 bits.
          v = pos[i];
          for (int j = 0; j < 3; j++) v -= round_shift(prod[i][j] * piv[j], mmb_pkg::FRAC_BITS);
        end
        e[i] = clamp32(v);
      end
      c.col  = col[1:0];
      c.row0 = e[0];
      c.row1 = e[1];
      c.row2 = e[2];
      c.row3 = (col == 3) ? mmb_pkg::ONE_FIX : 32'd0;
      c.last = (col == 3);
      expected_columns.push_back(c);
    end
  endtask

  function automatic logic [367:0] pack_xform(input logic [31:0] p[3], input logic [25:0] r[3],
                                              input logic [31:0] s[3], input logic [31:0] v[3]);
    logic [367:0] d;
    d = '0;
    for (int i = 0; i < 3; i++) begin
      d[32*i +: 32]        = p[i];
      d[96 + 26*i +: 26]   = r[i];
      d[174 + 32*i +: 32]  = s[i];
      d[270 + 32*i +: 32]  = v[i];
    end
    return d;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return ($urandom_range(0, 1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $signed($urandom_range(0, 8 << 16)) - (4 << 16);
    endcase
  endfunction

  function automatic logic [25:0] rand_angle();
    case ($urandom_range(0, 7))
      0: return 26'($urandom);
      1: return ($urandom_range(0, 1)) ? 26'sd23592960 : -26'sd23592960;
      2: return 26'($signed($urandom_range(0, 8)) * (45 << 16));
      default: return 26'($signed($urandom_range(0, 47185920)) - 23592960);
    endcase
  endfunction

  // Fills the queue of transforms: a directed set first, then random ones.
  initial begin
    logic [31:0] p[3], s[3], v[3];
    logic [25:0] r[3];
    for (int n = 0; n < 22; n++) begin
      for (int i = 0; i < 3; i++) begin
        p[i] = '0; s[i] = mmb_pkg::ONE_FIX; v[i] = '0; r[i] = '0;
      end
      case (n)
        0: ;
        1: for (int i = 0; i < 3; i++) r[i] = 26'sd23592960;
        2: for (int i = 0; i < 3; i++) r[i] = -26'sd23592960;
        3: r[0] = 26'(90 << 16);
        4: r[1] = 26'(90 << 16);
        5: r[2] = 26'(90 << 16);
        6: for (int i = 0; i < 3; i++) r[i] = 26'(-(180 << 16));
        7: for (int i = 0; i < 3; i++) r[i] = 26'h1FF_FFFF;
        8: for (int i = 0; i < 3; i++) r[i] = 26'h200_0000;
        9: for (int i = 0; i < 3; i++) begin p[i] = 32'h7FFF_FFFF; s[i] = 32'h7FFF_FFFF; end
        10: for (int i = 0; i < 3; i++) begin p[i] = 32'h8000_0000; s[i] = 32'h8000_0000; end
        11: for (int i = 0; i < 3; i++) begin s[i] = 32'h7FFF_FFFF; v[i] = 32'h8000_0000; end
        12: for (int i = 0; i < 3; i++) begin s[i] = 32'h8000_0000; v[i] = 32'h8000_0000; end
        13: for (int i = 0; i < 3; i++) begin p[i] = 32'hFFFF_FFFF; v[i] = 32'h7FFF_FFFF; end
        14: for (int i = 0; i < 3; i++) begin r[i] = 26'(45 << 16); v[i] = 32'h0001_8000; end
        15: for (int i = 0; i < 3; i++) r[i] = 26'd1;
        16: for (int i = 0; i < 3; i++) r[i] = 26'd2880;
        17: for (int i = 0; i < 3; i++) r[i] = -26'sd2880;
        18: for (int i = 0; i < 3; i++) s[i] = '0;
        default: for (int i = 0; i < 3; i++) begin
          p[i] = $urandom; s[i] = $urandom; v[i] = $urandom; r[i] = 26'($urandom);
        end
      endcase
      pending_xforms.push_back(pack_xform(p, r, s, v));
    end
    for (int n = 0; n < 300; n++) begin
      for (int i = 0; i < 3; i++) begin
        p[i] = rand_word(); s[i] = rand_word(); v[i] = rand_word(); r[i] = rand_angle();
      end
      pending_xforms.push_back(pack_xform(p, r, s, v));
    end
  end

  // Idling windows: random gaps on both sides, except a quiet stretch mid-run.
  always @(negedge clk) begin
    in_quiet  <= (cycle_count > 800 && cycle_count < 1600);
    out_quiet <= (cycle_count > 1200 && cycle_count < 2000);
  end

  // Driver: presents one transaction at a time, changes inputs on the falling edge.
  // After item 150 it holds off once until every expected column has come.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready_seen) begin
      if (pending_xforms.size() > 0 && !(sent_count == 150 && !drained_once) &&
          (in_quiet || $urandom_range(0, 99) >= 6)) begin
        in_tdata  <= pending_xforms.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
      if (sent_count == 150 && !drained_once && expected_columns.size() == 0) begin
        drained_once = 1'b1;
      end
    end
    out_tready <= out_quiet || ($urandom_range(0, 99) >= 6);
  end

  // Acceptance on the rising edge; the prediction is made here.
  always @(posedge clk) begin
    in_tready_seen = 1'b0;
    if (rst_n && in_tvalid && in_tready) begin
      in_tready_seen = 1'b1;
      predict_matrix(in_tdata);
      sent_count++;
    end
  end

  // Monitor: each accepted column is checked against the oldest expectation.
  always @(posedge clk) begin
    column_t c;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_columns.size() == 0) begin
        $error("unexpected column transaction, column_index %0d", out_tuser);
        failures++;
      end else begin
        c = expected_columns.pop_front();
        if (out_tuser !== c.col) begin
          $error("column_index expected %0d actual %0d", c.col, out_tuser);
          failures++;
        end
        if (out_tdata[31:0] !== c.row0) begin
          $error("elem_row0 expected %h actual %h", c.row0, out_tdata[31:0]);
          failures++;
        end
        if (out_tdata[63:32] !== c.row1) begin
          $error("elem_row1 expected %h actual %h", c.row1, out_tdata[63:32]);
          failures++;
        end
        if (out_tdata[95:64] !== c.row2) begin
          $error("elem_row2 expected %h actual %h", c.row2, out_tdata[95:64]);
          failures++;
        end
        if (out_tdata[127:96] !== c.row3) begin
          $error("elem_row3 expected %h actual %h", c.row3, out_tdata[127:96]);
          failures++;
        end
        if (out_tlast !== c.last) begin
          $error("last_column expected %0d actual %0d", c.last, out_tlast);
          failures++;
        end
      end
    end
  end

  // Reset, run control and the final verdict.
  initial begin
    failures      = 0;
    cycle_count   = 0;
    sent_count    = 0;
    drained_once  = 1'b0;
    in_quiet      = 1'b0;
    out_quiet     = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    out_tready    = 1'b0;
    in_tready_seen = 1'b0;
    rst_n         = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    wait (sent_count == 322);
    wait (expected_columns.size() == 0);
    repeat (40) @(posedge clk);
    if (failures == 0 && expected_columns.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Timeout: far beyond the slowest correct run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == 200000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule

// ===== model_matrix_builder.f =====
+incdir+sv
sv/mmb_pkg.sv
sv/mmb_angle.sv
sv/mmb_qsin.sv
sv/mmb_rot.sv
sv/mmb_col.sv
sv/model_matrix_builder.sv
tb/model_matrix_builder_tb.sv
